FILE: rtl/cosine_similarity_scorer_unit_defines.svh
// Assertion macros shared by the cosine similarity scorer RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef COSINE_SIMILARITY_SCORER_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_SCORER_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define CSIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define CSIM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/csim_pkg.sv
// Types and constants for the cosine similarity scorer.
// No dependencies; used by every module of the block.
`default_nettype none

package csim_pkg;

  localparam int ElemW    = 16;           // element width, Q1.15
  localparam int ProdW    = 2 * ElemW;    // signed a*b
  localparam int SqW      = 2 * ElemW - 1; // a*a, at most 2^30
  localparam int DotW     = 41;
  localparam int NormW    = 40;
  localparam int ScoreW   = 16;
  localparam int NrmW     = 62;           // normalised norm, [2^60, 2^62)
  localparam int RootW    = 31;           // root of a normalised norm
  localparam int DenW     = 2 * RootW;
  localparam int RemW     = DenW + 1;
  localparam int KW       = 5;            // shift pairs, 0..30
  localparam int StepW    = 7;            // divide steps, up to 75
  localparam int QW       = 18;           // quotient incl. saturation headroom
  localparam int DivExtra = 15;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QLvlW    = $clog2(QDepth + 1);

  localparam logic [QW-1:0] QSat      = QW'(65536);
  localparam logic [QW-1:0] ScoreHalf = QW'(32768);
  localparam logic [QW-1:0] ScoreTop  = QW'(65535);

  typedef struct packed {
    logic signed [ElemW-1:0] a_value;
    logic signed [ElemW-1:0] b_value;
    logic                    last_pair;
  } csim_in_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              degenerate;
    logic              overflow;
  } csim_out_t;

  // one closed vector pair, handed from accumulator to score engine
  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [NormW-1:0]       norm_a;
    logic [NormW-1:0]       norm_b;
    logic                   too_many;
  } csim_job_t;

  typedef struct packed {
    logic      push;
    csim_job_t job;
  } csim_push_t;

  typedef struct packed {
    logic full;
    logic afull;
    logic empty;
  } csim_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/cosine_similarity_scorer_unit.sv
// Cosine similarity scorer: one element pair per cycle while busy is low.
// The score engine normalises each norm with ka, kb (0..30) shift pairs.
// Throughput: one pair per cycle; the serial score engine (31-step root,
// up to 75-step divide) with a two-deep job queue raises busy on short vectors.
// Asynchronous active-low reset clears sums, counts, queue and engine; no clearing pass.
`default_nettype none

module cosine_similarity_scorer_unit #(
  parameter int MAX_ELEMENTS = 512
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  csim_pkg::csim_in_t  item_i,
  output logic                res_valid_o,
  output csim_pkg::csim_out_t res_o
);
  import csim_pkg::*;

  logic        accept, pending_last, pop;
  csim_push_t  push;
  csim_qstat_t qstat;
  csim_job_t   job;

  assign busy   = qstat.full | (qstat.afull & pending_last);
  assign accept = start & ~busy;

  csim_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item_i),
    .pending_last_o(pending_last),
    .push_o        (push)
  );

  csim_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .job_o (job),
    .stat_o(qstat)
  );

  csim_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (qstat.empty),
    .job_i      (job),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

FILE: rtl/csim_front.sv
// Front end: element pair accumulator (dot product, two sums of squares, count).
// Depends on csim_pkg; hands each closed vector to the job queue.
`default_nettype none

module csim_front #(
  parameter int MAX_ELEMENTS = 512
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   accept_i,
  input  csim_pkg::csim_in_t    item_i,
  output logic                  pending_last_o,
  output csim_pkg::csim_push_t  push_o
);
  import csim_pkg::*;

  localparam int CntW = $clog2(MAX_ELEMENTS + 1);

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    tm_q, tm_d;
  logic                    use_pair;
  logic                    s1_valid_q, s1_last_q, s1_use_q, s1_tm_q;
  logic signed [ProdW-1:0] prod_ab_q;
  logic [SqW-1:0]          prod_aa_q, prod_bb_q;
  logic signed [ProdW-1:0] mul_ab, mul_aa, mul_bb;
  logic signed [DotW-1:0]  dot_q, dot_next;
  logic [NormW-1:0]        na_q, nb_q, na_next, nb_next;

  assign use_pair = cnt_q < CntW'(MAX_ELEMENTS);
  assign mul_ab   = item_i.a_value * item_i.b_value;
  assign mul_aa   = item_i.a_value * item_i.a_value;
  assign mul_bb   = item_i.b_value * item_i.b_value;

  always_comb begin
    cnt_d = cnt_q;
    tm_d  = tm_q;
    if (accept_i) begin
      if (item_i.last_pair) begin
        cnt_d = '0;
        tm_d  = 1'b0;
      end else begin
        if (use_pair) cnt_d = cnt_q + CntW'(1);
        tm_d = tm_q | ~use_pair;
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      tm_q       <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_use_q   <= 1'b0;
      s1_tm_q    <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      tm_q       <= tm_d;
      s1_valid_q <= accept_i;
      s1_last_q  <= item_i.last_pair;
      s1_use_q   <= use_pair;
      s1_tm_q    <= tm_q | ~use_pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      prod_ab_q <= mul_ab;
      prod_aa_q <= mul_aa[SqW-1:0];
      prod_bb_q <= mul_bb[SqW-1:0];
    end
  end

  always_comb begin
    dot_next = dot_q;
    na_next  = na_q;
    nb_next  = nb_q;
    if (s1_use_q) begin
      dot_next = dot_q + {{(DotW-ProdW){prod_ab_q[ProdW-1]}}, prod_ab_q};
      na_next  = na_q + {{(NormW-SqW){1'b0}}, prod_aa_q};
      nb_next  = nb_q + {{(NormW-SqW){1'b0}}, prod_bb_q};
    end
  end

  // accumulate stage; sums clear once a vector closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else begin
        dot_q <= dot_next;
        na_q  <= na_next;
        nb_q  <= nb_next;
      end
    end
  end

  assign pending_last_o       = s1_valid_q & s1_last_q;
  assign push_o.push          = s1_valid_q & s1_last_q;
  assign push_o.job.dot       = dot_next;
  assign push_o.job.norm_a    = na_next;
  assign push_o.job.norm_b    = nb_next;
  assign push_o.job.too_many  = s1_tm_q;

endmodule

`default_nettype wire

FILE: rtl/csim_fifo.sv
// Short job queue between accumulator and score engine.
// Depends on csim_pkg and the assertion macro header.
`default_nettype none
`include "cosine_similarity_scorer_unit_defines.svh"

module csim_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  csim_pkg::csim_push_t  push_i,
  input  wire                   pop_i,
  output csim_pkg::csim_job_t   job_o,
  output csim_pkg::csim_qstat_t stat_o
);
  import csim_pkg::*;

  csim_job_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QLvlW-1:0] lvl_q;

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wr_q] <= push_i.job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i.push) wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      if (pop_i)       rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      case ({push_i.push, pop_i})
        2'b10:   lvl_q <= lvl_q + QLvlW'(1);
        2'b01:   lvl_q <= lvl_q - QLvlW'(1);
        default: lvl_q <= lvl_q;
      endcase
    end
  end

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = lvl_q == QLvlW'(QDepth);
  assign stat_o.afull = lvl_q >= QLvlW'(QDepth - 1);
  assign stat_o.empty = lvl_q == '0;

  `CSIM_NEVER(a_no_push_full, push_i.push && !pop_i && stat_o.full, "job queue overrun")
  `CSIM_NEVER(a_no_pop_empty, pop_i && stat_o.empty, "job queue underrun")
  `CSIM_ASSERT(a_lvl_ptrs, (lvl_q == '0 || lvl_q == QLvlW'(QDepth)) |-> (wr_q == rd_q),
               "queue level disagrees with pointers")

endmodule

`default_nettype wire

FILE: rtl/csim_back.sv
// Back end: norm normalisation, paired square roots, multiply and
// restoring divide to the Q0.16 score. Depends on csim_pkg and macro header.
`default_nettype none
`include "cosine_similarity_scorer_unit_defines.svh"

module csim_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   empty_i,
  input  csim_pkg::csim_job_t   job_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output csim_pkg::csim_out_t   res_o
);
  import csim_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_NORM = 6'b000010,
    ST_SQRT = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } bstate_e;

  bstate_e                state_q, state_d;
  logic [NrmW-1:0]        va_q, vb_q, resa_q, resb_q, bit_q;
  logic [KW-1:0]          ka_q, kb_q;
  logic signed [DotW-1:0] dot_q;
  logic                   tm_q;
  logic [DenW-1:0]        den_q;
  logic [RemW-1:0]        rem_q;
  logic [QW-1:0]          q_q;
  logic [StepW-1:0]       steps_q;
  logic                   neg_q;
  logic                   res_valid_q;
  csim_out_t              res_q;

  logic                   norm_a_ok, norm_b_ok, degen;
  logic [NrmW-1:0]        trial_a, trial_b;
  logic [DotW-1:0]        mag;
  logic [RemW-1:0]        rem_sh, rem_nx;
  logic [QW-1:0]          q_nx, ceil_q, pos_q;
  logic [ScoreW-1:0]      score_fin;

  assign norm_a_ok = |va_q[NrmW-1 -: 2];
  assign norm_b_ok = |vb_q[NrmW-1 -: 2];
  assign degen     = (job_i.norm_a == '0) || (job_i.norm_b == '0);
  assign trial_a   = resa_q + bit_q;
  assign trial_b   = resb_q + bit_q;
  assign mag       = dot_q[DotW-1] ? (~dot_q + DotW'(1)) : dot_q;

  // one restoring divide step
  always_comb begin
    rem_sh = {rem_q[RemW-2:0], 1'b0};
    q_nx   = {q_q[QW-2:0], 1'b0};
    rem_nx = rem_sh;
    if (rem_sh >= {1'b0, den_q}) begin
      rem_nx  = rem_sh - {1'b0, den_q};
      q_nx[0] = 1'b1;
    end
  end

  // negative cosine rounds the magnitude up
  always_comb begin
    ceil_q = q_q + ((rem_q != '0) ? QW'(1) : QW'(0));
    pos_q  = q_q + ScoreHalf;
    if (neg_q) begin
      score_fin = (ceil_q >= ScoreHalf) ? '0 : ScoreW'(ScoreHalf - ceil_q);
    end else begin
      score_fin = (pos_q > ScoreTop) ? ScoreTop[ScoreW-1:0] : pos_q[ScoreW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!degen) state_d = ST_NORM;
        end
      end
      ST_NORM: if (norm_a_ok && norm_b_ok) state_d = ST_SQRT;
      ST_SQRT: if (bit_q[0]) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (q_nx > QSat || steps_q == StepW'(1)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_IDLE && pop_o && degen) || state_q == ST_FIN;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        dot_q <= job_i.dot;
        tm_q  <= job_i.too_many;
        va_q  <= {{(NrmW-NormW){1'b0}}, job_i.norm_a};
        vb_q  <= {{(NrmW-NormW){1'b0}}, job_i.norm_b};
        ka_q  <= '0;
        kb_q  <= '0;
        resa_q <= '0;
        resb_q <= '0;
        bit_q  <= NrmW'(1) << (NrmW - 2);
        if (pop_o && degen) begin
          res_q.score      <= '0;
          res_q.degenerate <= 1'b1;
          res_q.overflow   <= job_i.too_many;
        end
      end
      ST_NORM: begin
        if (!norm_a_ok) begin
          va_q <= va_q << 2;
          ka_q <= ka_q + KW'(1);
        end
        if (!norm_b_ok) begin
          vb_q <= vb_q << 2;
          kb_q <= kb_q + KW'(1);
        end
      end
      ST_SQRT: begin
        if (va_q >= trial_a) begin
          va_q   <= va_q - trial_a;
          resa_q <= (resa_q >> 1) + bit_q;
        end else begin
          resa_q <= resa_q >> 1;
        end
        if (vb_q >= trial_b) begin
          vb_q   <= vb_q - trial_b;
          resb_q <= (resb_q >> 1) + bit_q;
        end else begin
          resb_q <= resb_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_MUL: begin
        den_q   <= resa_q[RootW-1:0] * resb_q[RootW-1:0];
        rem_q   <= {{(RemW-DotW){1'b0}}, mag};
        q_q     <= '0;
        neg_q   <= dot_q[DotW-1];
        steps_q <= StepW'(ka_q) + StepW'(kb_q) + StepW'(DivExtra);
      end
      ST_DIV: begin
        rem_q   <= rem_nx;
        q_q     <= (q_nx > QSat) ? QSat : q_nx;
        steps_q <= steps_q - StepW'(1);
      end
      ST_FIN: begin
        res_q.score      <= score_fin;
        res_q.degenerate <= 1'b0;
        res_q.overflow   <= tm_q;
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `CSIM_ASSERT(a_res_src, res_valid_q |-> ($past(state_q) == ST_FIN ||
               $past(state_q) == ST_IDLE), "result strobe from a working state")
  `CSIM_NEVER(a_q_bound, state_q == ST_DIV && q_q > QSat, "quotient beyond saturation")
  `CSIM_ASSERT(a_sqrt_norm, (state_q == ST_SQRT && $past(state_q) == ST_NORM) |->
               (norm_a_ok && norm_b_ok), "square root started on an unnormalised norm")

endmodule

`default_nettype wire
